// File: sv/ods_pkg.sv
// Package with the request and response types and helpers of the omitted date set.
`default_nettype none
package ods_pkg;

  localparam int DAY_W  = 22;
  localparam int MON_W  = 4;
  localparam int DOM_W  = 5;
  localparam int MASK_W = 7;
  localparam int KEY_W  = MON_W + DOM_W;

  typedef enum logic [1:0] {
    OP_CLEAR      = 2'd0,
    OP_ADD_FULL   = 2'd1,
    OP_ADD_YEARLY = 2'd2,
    OP_QUERY      = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DAY_W-1:0]  day_number;
    logic [MON_W-1:0]  month;
    logic [DOM_W-1:0]  day_of_month;
    logic [MASK_W-1:0] weekday_mask;
  } in_req_t;

  typedef struct packed {
    logic omitted;
    logic status;
  } out_rsp_t;

  // Since 8 is 1 modulo 7, the octal digits of a value sum to the same residue.
  function automatic logic [2:0] day_mod7(input logic [DAY_W-1:0] dn);
    logic [5:0]        s;
    logic [3:0]        t;
    logic [2:0]        r;
    logic [DAY_W+1:0]  ext;
    int                i;
    ext = {2'b00, dn};
    s   = '0;
    for (i = 0; i < 8; i++) begin
      s = s + {3'b000, ext[3*i +: 3]};
    end
    t = {1'b0, s[5:3]} + {1'b0, s[2:0]};
    r = {2'b00, t[3]} + t[2:0];
    if (r == 3'd7) begin
      r = 3'd0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/omitted_date_set_core.sv
// Top level of the omitted date set: sorted full and yearly date tables with search and insert.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready   | ods_pkg::in_req_t
//   out_    | output    | out_valid / out_ready | ods_pkg::out_rsp_t
//
// One request at a time goes through one shared compare unit; in_ready is high only when idle.
// A clear or a refused add goes straight to the result; a query checks the weekday mask first.
// A table search is a binary search of k probes, each a read then a compare; k is at most log2(n+1) rounded up.
// A query searches the full table, then the yearly one; an add that misses moves larger entries up, then writes.
// Reset is synchronous and empties both tables through their counts; no clearing pass.
// A held result stalls the sequencer only when the next result is ready to load.
`default_nettype none
module omitted_date_set_core #(
  parameter int FULL_DEPTH   = 256,
  parameter int YEARLY_DEPTH = 512
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ods_pkg::in_req_t   in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ods_pkg::out_rsp_t       out_data
);
  import ods_pkg::*;

  localparam int FAW = (FULL_DEPTH > 1) ? $clog2(FULL_DEPTH) : 1;
  localparam int YAW = (YEARLY_DEPTH > 1) ? $clog2(YEARLY_DEPTH) : 1;
  localparam int FCW = $clog2(FULL_DEPTH + 1);
  localparam int YCW = $clog2(YEARLY_DEPTH + 1);
  localparam int PW  = (FCW > YCW) ? FCW : YCW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WDAY,
    S_SRCH,
    S_SCMP,
    S_SHRD,
    S_SHCMP,
    S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic [DAY_W-1:0]   key_r, key_nxt;
  logic [DAY_W-1:0]   dn_r, dn_nxt;
  logic [KEY_W-1:0]   ykey_r, ykey_nxt;
  logic [MASK_W-1:0]  wmask_r, wmask_nxt;
  logic               sel_r, sel_nxt;
  logic [PW-1:0]      lo_r, lo_nxt;
  logic [PW-1:0]      hi_r, hi_nxt;
  logic [PW-1:0]      mid_r, mid_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic [FCW-1:0]     full_cnt_r, full_cnt_nxt;
  logic [YCW-1:0]     yr_cnt_r, yr_cnt_nxt;
  out_rsp_t           res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_rsp_t           out_data_r, out_data_nxt;

  logic               rd_en;
  logic [PW-1:0]      rd_ptr;
  logic               wr_en;
  logic [DAY_W-1:0]   wr_word;
  logic [DAY_W-1:0]   full_rdata;
  logic [KEY_W-1:0]   yr_rdata;
  logic [DAY_W-1:0]   rd_word;
  logic [PW-1:0]      mid_calc;
  logic [2:0]         dn_mod7;

  assign rd_word  = sel_r ? {{(DAY_W-KEY_W){1'b0}}, yr_rdata} : full_rdata;
  assign mid_calc = lo_r + ((hi_r - lo_r) >> 1);
  assign dn_mod7  = day_mod7(dn_r);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    dn_nxt        = dn_r;
    ykey_nxt      = ykey_r;
    wmask_nxt     = wmask_r;
    sel_nxt       = sel_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    pos_nxt       = pos_r;
    full_cnt_nxt  = full_cnt_r;
    yr_cnt_nxt    = yr_cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_ptr        = mid_calc;
    wr_en         = 1'b0;
    wr_word       = key_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.op;
          dn_nxt    = in_data.day_number;
          ykey_nxt  = {in_data.month, in_data.day_of_month};
          wmask_nxt = in_data.weekday_mask;
          res_nxt   = '0;
          lo_nxt    = '0;
          case (in_data.op)
            OP_CLEAR: begin
              full_cnt_nxt = '0;
              yr_cnt_nxt   = '0;
              state_nxt    = S_DONE;
            end
            OP_ADD_FULL: begin
              sel_nxt = 1'b0;
              key_nxt = in_data.day_number;
              hi_nxt  = PW'(full_cnt_r);
              pos_nxt = PW'(full_cnt_r);
              if (full_cnt_r >= FCW'(FULL_DEPTH)) begin
                res_nxt.status = 1'b1;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            OP_ADD_YEARLY: begin
              sel_nxt = 1'b1;
              key_nxt = {{(DAY_W-KEY_W){1'b0}}, in_data.month, in_data.day_of_month};
              hi_nxt  = PW'(yr_cnt_r);
              pos_nxt = PW'(yr_cnt_r);
              if (yr_cnt_r >= YCW'(YEARLY_DEPTH)) begin
                res_nxt.status = 1'b1;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            OP_QUERY: begin
              sel_nxt   = 1'b0;
              key_nxt   = in_data.day_number;
              hi_nxt    = PW'(full_cnt_r);
              state_nxt = S_WDAY;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_WDAY: begin
        if (wmask_r[dn_mod7]) begin
          res_nxt.omitted = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          rd_en     = 1'b1;
          rd_ptr    = mid_calc;
          mid_nxt   = mid_calc;
          state_nxt = S_SCMP;
        end else if (op_r != OP_QUERY) begin
          state_nxt = S_SHRD;
        end else if (!sel_r) begin
          sel_nxt = 1'b1;
          key_nxt = {{(DAY_W-KEY_W){1'b0}}, ykey_r};
          lo_nxt  = '0;
          hi_nxt  = PW'(yr_cnt_r);
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCMP: begin
        if (rd_word == key_r) begin
          if (op_r == OP_QUERY) begin
            res_nxt.omitted = 1'b1;
          end
          state_nxt = S_DONE;
        end else begin
          if (rd_word > key_r) begin
            hi_nxt = mid_r;
          end else begin
            lo_nxt = mid_r + 1'b1;
          end
          state_nxt = S_SRCH;
        end
      end
      S_SHRD: begin
        if (pos_r != '0) begin
          rd_en     = 1'b1;
          rd_ptr    = pos_r - 1'b1;
          state_nxt = S_SHCMP;
        end else begin
          wr_en     = 1'b1;
          wr_word   = key_r;
          state_nxt = S_DONE;
          if (sel_r) begin
            yr_cnt_nxt = yr_cnt_r + 1'b1;
          end else begin
            full_cnt_nxt = full_cnt_r + 1'b1;
          end
        end
      end
      S_SHCMP: begin
        wr_en = 1'b1;
        if (rd_word > key_r) begin
          wr_word   = rd_word;
          pos_nxt   = pos_r - 1'b1;
          state_nxt = S_SHRD;
        end else begin
          wr_word   = key_r;
          state_nxt = S_DONE;
          if (sel_r) begin
            yr_cnt_nxt = yr_cnt_r + 1'b1;
          end else begin
            full_cnt_nxt = full_cnt_r + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      full_cnt_r  <= '0;
      yr_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      full_cnt_r  <= full_cnt_nxt;
      yr_cnt_r    <= yr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    dn_r       <= dn_nxt;
    ykey_r     <= ykey_nxt;
    wmask_r    <= wmask_nxt;
    sel_r      <= sel_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    pos_r      <= pos_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  ods_ram #(
    .WIDTH (DAY_W),
    .DEPTH (FULL_DEPTH)
  ) u_full_ram (
    .clk   (clk),
    .we    (wr_en && !sel_r),
    .waddr (pos_r[FAW-1:0]),
    .wdata (wr_word),
    .re    (rd_en && !sel_r),
    .raddr (rd_ptr[FAW-1:0]),
    .rdata (full_rdata)
  );

  ods_ram #(
    .WIDTH (KEY_W),
    .DEPTH (YEARLY_DEPTH)
  ) u_yr_ram (
    .clk   (clk),
    .we    (wr_en && sel_r),
    .waddr (pos_r[YAW-1:0]),
    .wdata (wr_word[KEY_W-1:0]),
    .re    (rd_en && sel_r),
    .raddr (rd_ptr[YAW-1:0]),
    .rdata (yr_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// File: sv/ods_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module ods_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: sv/ods_checker.sv
// Port-level checker for the omitted date set core, with its bind statement.
`default_nettype none
module ods_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire ods_pkg::in_req_t  in_data,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire ods_pkg::out_rsp_t out_data
);
  import ods_pkg::*;

  logic unused_in;
  assign unused_in = ^in_data;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Core accepted a request while still busy.");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.omitted && out_data.status))
    else $error("Response carries both omitted and status.");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Response valid after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled response changed.");

endmodule

bind omitted_date_set_core ods_checker u_ods_checker (.*);
`default_nettype wire

// File: sim/tb_omitted_date_set_core.sv
// Testbench for omitted_date_set_core: directed, table-fill and random requests checked against a behavioral model.
`timescale 1ns / 1ps
module tb_omitted_date_set_core;
  import ods_pkg::*;

  localparam int FULL_CAP     = 256;
  localparam int YEARLY_CAP   = 512;
  localparam int DAY_MAX      = (1 << DAY_W) - 1;
  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 2000;
  localparam int PHASE_ITEMS  = 30;

  class date_set_scoreboard;
    bit       full_days[bit [DAY_W-1:0]];
    bit       yearly_keys[bit [KEY_W-1:0]];
    out_rsp_t pending_verdicts[$];
    int       fail_count;

    function void note_request(in_req_t r);
      out_rsp_t         v;
      bit [KEY_W-1:0]   key;
      v   = '0;
      key = {r.month, r.day_of_month};
      case (r.op)
        OP_CLEAR: begin
          full_days.delete();
          yearly_keys.delete();
        end
        OP_ADD_FULL: begin
          if (full_days.num() >= FULL_CAP) begin
            v.status = 1'b1;
          end else begin
            full_days[r.day_number] = 1'b1;
          end
        end
        OP_ADD_YEARLY: begin
          if (yearly_keys.num() >= YEARLY_CAP) begin
            v.status = 1'b1;
          end else begin
            yearly_keys[key] = 1'b1;
          end
        end
        default: begin
          v.omitted = r.weekday_mask[r.day_number % 7] || full_days.exists(r.day_number)
                      || yearly_keys.exists(key);
        end
      endcase
      pending_verdicts.push_back(v);
    endfunction

    function void check_response(out_rsp_t got);
      out_rsp_t want;
      if (pending_verdicts.size() == 0) begin
        $error("Response with no request outstanding: omitted %b status %b",
               got.omitted, got.status);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (got.omitted !== want.omitted) begin
          $error("omitted: expected %b, got %b", want.omitted, got.omitted);
          fail_count++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %b, got %b", want.status, got.status);
          fail_count++;
        end
      end
    endfunction

    function int outstanding();
      return pending_verdicts.size();
    endfunction
  endclass

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_req_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_rsp_t out_data;

  date_set_scoreboard scoreboard;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  logic        hold_go     = 1'b0;
  logic        hold_seen   = 1'b0;
  int          hold_left   = 0;
  int          cycle_count = 0;
  bit [DAY_W-1:0] recent_days[$];
  bit [KEY_W-1:0] recent_keys[$];

  omitted_date_set_core #(
    .FULL_DEPTH  (FULL_CAP),
    .YEARLY_DEPTH(YEARLY_CAP)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      scoreboard.check_response(out_data);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic in_req_t make_req(op_t op, int unsigned dn, int unsigned mon,
                                       int unsigned dom, int unsigned mask);
    in_req_t r;
    r.op           = op;
    r.day_number   = DAY_W'(dn);
    r.month        = MON_W'(mon);
    r.day_of_month = DOM_W'(dom);
    r.weekday_mask = MASK_W'(mask);
    return r;
  endfunction

  task automatic send_request(input in_req_t r);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    scoreboard.note_request(r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (scoreboard.outstanding() != 0);
  endtask

  task automatic run_directed();
    send_request(make_req(OP_QUERY, 0, 0, 1, 0));
    send_request(make_req(OP_QUERY, DAY_MAX, 11, 31, 7'h7f));
    send_request(make_req(OP_QUERY, 7, 3, 5, 7'h01));
    send_request(make_req(OP_QUERY, 13, 3, 5, 7'h40));
    send_request(make_req(OP_ADD_FULL, 0, 0, 0, 7'h7f));
    send_request(make_req(OP_ADD_FULL, DAY_MAX, 15, 31, 7'h7f));
    send_request(make_req(OP_ADD_FULL, 0, 0, 0, 0));
    send_request(make_req(OP_ADD_FULL, 100, 2, 2, 0));
    send_request(make_req(OP_QUERY, 0, 1, 1, 0));
    send_request(make_req(OP_QUERY, DAY_MAX, 1, 1, 0));
    send_request(make_req(OP_QUERY, 50, 0, 0, 0));
    send_request(make_req(OP_ADD_YEARLY, 50, 0, 0, 7'h7f));
    send_request(make_req(OP_ADD_YEARLY, DAY_MAX, 15, 31, 0));
    send_request(make_req(OP_ADD_YEARLY, 0, 11, 31, 0));
    send_request(make_req(OP_ADD_YEARLY, 0, 15, 31, 0));
    send_request(make_req(OP_QUERY, 50, 0, 0, 0));
    send_request(make_req(OP_QUERY, 51, 11, 30, 0));
    send_request(make_req(OP_QUERY, 51, 11, 31, 0));
    send_request(make_req(OP_QUERY, 51, 15, 31, 0));
    send_request(make_req(OP_CLEAR, DAY_MAX, 15, 31, 7'h7f));
    send_request(make_req(OP_QUERY, 0, 0, 0, 0));
    send_request(make_req(OP_QUERY, DAY_MAX, 15, 31, 0));
  endtask

  task automatic fill_tables();
    int i;
    send_request(make_req(OP_CLEAR, 0, 0, 0, 0));
    for (i = 0; i < FULL_CAP; i++) begin
      send_request(make_req(OP_ADD_FULL, i * 16383 + 1, 0, 1, 0));
    end
    send_request(make_req(OP_ADD_FULL, 1, 0, 1, 0));
    send_request(make_req(OP_ADD_FULL, 5, 0, 1, 0));
    send_request(make_req(OP_QUERY, 128 * 16383 + 1, 0, 1, 0));
    send_request(make_req(OP_QUERY, 2, 0, 1, 0));
    send_request(make_req(OP_CLEAR, 0, 0, 0, 0));
    for (i = 0; i < YEARLY_CAP; i++) begin
      send_request(make_req(OP_ADD_YEARLY, i, i >> 5, i & 31, 0));
    end
    send_request(make_req(OP_ADD_YEARLY, 9, 4, 4, 0));
    send_request(make_req(OP_QUERY, 9, 7, 19, 0));
    send_request(make_req(OP_ADD_FULL, 9, 0, 0, 0));
    send_request(make_req(OP_CLEAR, 0, 0, 0, 0));
  endtask

  task automatic make_random_request(output in_req_t r);
    int pick;
    pick = $urandom_range(99);
    if (pick < 3) begin
      r.op = OP_CLEAR;
    end else if (pick < 33) begin
      r.op = OP_ADD_FULL;
    end else if (pick < 60) begin
      r.op = OP_ADD_YEARLY;
    end else begin
      r.op = OP_QUERY;
    end
    r.day_number = DAY_W'($urandom_range(DAY_MAX));
    if ($urandom_range(99) < 30) begin
      r.day_number = DAY_W'($urandom_range(99));
    end
    if (recent_days.size() != 0 && $urandom_range(99) < 40) begin
      r.day_number = recent_days[$urandom_range(recent_days.size() - 1)];
    end
    r.month        = MON_W'($urandom_range(15));
    r.day_of_month = DOM_W'($urandom_range(31));
    if (recent_keys.size() != 0 && $urandom_range(99) < 40) begin
      {r.month, r.day_of_month} = recent_keys[$urandom_range(recent_keys.size() - 1)];
    end
    r.weekday_mask = ($urandom_range(1) == 0) ? '0 : MASK_W'($urandom_range(127));
    case (r.op)
      OP_CLEAR: begin
        recent_days.delete();
        recent_keys.delete();
      end
      OP_ADD_FULL:   recent_days.push_back(r.day_number);
      OP_ADD_YEARLY: recent_keys.push_back({r.month, r.day_of_month});
      default: ;
    endcase
  endtask

  task automatic run_random(input int count);
    in_req_t r;
    int      i;
    for (i = 0; i < count; i++) begin
      make_random_request(r);
      send_request(r);
    end
  endtask

  initial begin
    scoreboard = new();
    repeat (4) @(posedge clk);
    rst_n       <= 1'b1;
    tx_idle_pct = 31;
    rx_idle_pct <= 51;
    run_directed();
    fill_tables();
    wait_drained();
    run_random(PHASE_ITEMS);
    wait_drained();
    tx_idle_pct = 51;
    rx_idle_pct <= 31;
    run_random(PHASE_ITEMS);
    wait_drained();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_go     <= ~hold_go;
    run_random(PHASE_ITEMS);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (scoreboard.fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
